// File: hw/rtl/csvirc_pkg.sv
// Shared types and constants for the CSV incomplete-record checker.
`default_nettype none

package csvirc_pkg;

   localparam logic [7:0] NEWLINE_BYTE = 8'd10;

   // Control register indexes on the csr_ port
   localparam logic [1:0] REG_EXPECTED_FIELDS = 2'd0;
   localparam logic [1:0] REG_DELIMITER_CHAR  = 2'd1;
   localparam logic [1:0] REG_FIELD_CAPACITY  = 2'd2;

   localparam logic [3:0] EXPECTED_FIELDS_RST = 4'd7;
   localparam logic [7:0] DELIMITER_CHAR_RST  = 8'd44;
   localparam logic [4:0] FIELD_CAPACITY_RST  = 5'd19;

   typedef struct packed {
      logic [3:0] expected_fields;
      logic [7:0] delimiter_char;
      logic [4:0] field_capacity;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  char_out;
      logic        store_enable;
      logic [3:0]  column_index;
      logic [4:0]  char_position;
      logic        field_end;
      logic        field_empty;
      logic        field_overflow;
      logic        row_end;
      logic        row_incomplete;
      logic [15:0] row_number;
      logic [15:0] incomplete_total;
   } result_type;

endpackage

`default_nettype wire

// File: hw/rtl/csv_incomplete_record_check_top.sv
// Top level: handshakes, control registers and result register of the CSV checker.
// A result is registered and becomes valid in the cycle after its input transaction is accepted.
// Throughput: one byte per cycle; the result register frees itself in the cycle it
//   is taken, so req_ready stays high under continuous rsp_ready.
// Control writes are accepted every cycle (csr_ready is always high).
// Synchronous active-high reset clears tracking state, counters and rsp_valid and
//   loads the control registers with their defaults; no clearing pass is needed.
`default_nettype none

module csv_incomplete_record_check_top
   import csvirc_pkg::*;
#(
   parameter int MAX_COLUMNS    = 16,
   parameter int FIELD_BYTES    = 32,
   parameter int ROW_COUNT_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_char_out,
   output logic             rsp_store_enable,
   output logic [3:0]       rsp_column_index,
   output logic [4:0]       rsp_char_position,
   output logic             rsp_field_end,
   output logic             rsp_field_empty,
   output logic             rsp_field_overflow,
   output logic             rsp_row_end,
   output logic             rsp_row_incomplete,
   output logic [15:0]      rsp_row_number,
   output logic [15:0]      rsp_incomplete_total
);

   localparam int COL_TOP = (MAX_COLUMNS - 1 > 15) ? 15 : MAX_COLUMNS - 1;
   localparam int COL_W   = $clog2(COL_TOP + 1);
   localparam int POS_TOP = (FIELD_BYTES - 1 > 31) ? 31 : FIELD_BYTES - 1;
   localparam int POS_W   = $clog2(POS_TOP + 1);
   localparam int CNT_W   = (ROW_COUNT_BITS > 16) ? 16 : ROW_COUNT_BITS;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   result_type result;
   result_type result_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       req_accept;

   assign csr_ready  = 1'b1;
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_EXPECTED_FIELDS: cfg_in.expected_fields = csr_wdata[3:0];
            REG_DELIMITER_CHAR:  cfg_in.delimiter_char  = csr_wdata;
            REG_FIELD_CAPACITY:  cfg_in.field_capacity  = csr_wdata[4:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   csvirc_core #(
      .COL_W   (COL_W),
      .COL_TOP (COL_TOP),
      .POS_W   (POS_W),
      .POS_TOP (POS_TOP),
      .CNT_W   (CNT_W)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (req_accept),
      .cfg       (cfg_ff),
      .data_byte (req_data_byte),
      .result    (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_fields <= EXPECTED_FIELDS_RST;
         cfg_ff.delimiter_char  <= DELIMITER_CHAR_RST;
         cfg_ff.field_capacity  <= FIELD_CAPACITY_RST;
         rsp_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_char_out         = result_ff.char_out;
   assign rsp_store_enable     = result_ff.store_enable;
   assign rsp_column_index     = result_ff.column_index;
   assign rsp_char_position    = result_ff.char_position;
   assign rsp_field_end        = result_ff.field_end;
   assign rsp_field_empty      = result_ff.field_empty;
   assign rsp_field_overflow   = result_ff.field_overflow;
   assign rsp_row_end          = result_ff.row_end;
   assign rsp_row_incomplete   = result_ff.row_incomplete;
   assign rsp_row_number       = result_ff.row_number;
   assign rsp_incomplete_total = result_ff.incomplete_total;

   a_accept_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted transaction produced no result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !req_accept)
      else $error("pending result overwritten");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ready && !req_accept |=> !rsp_valid_ff)
      else $error("result repeated after hand-off");

endmodule

`default_nettype wire

// File: hw/rtl/csvirc_core.sv
// Field/row tracking state and per-byte result evaluation.
`default_nettype none

module csvirc_core
   import csvirc_pkg::*;
#(
   parameter int COL_W   = 4,
   parameter int COL_TOP = 15,
   parameter int POS_W   = 5,
   parameter int POS_TOP = 31,
   parameter int CNT_W   = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire cfg_type    cfg,
   input  wire logic [7:0] data_byte,
   output result_type      result
);

   localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(COL_TOP);
   localparam logic [4:0]       POS_LIMIT = 5'(POS_TOP);

   logic [COL_W-1:0] col_ff, col_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             gap_ff, gap_in;
   logic [CNT_W-1:0] row_cnt_ff, row_cnt_in;
   logic [CNT_W-1:0] gap_cnt_ff, gap_cnt_in;

   logic [4:0]       cap_eff;
   logic [4:0]       pos_top;
   logic [4:0]       pos_x;
   logic [4:0]       col_x;
   logic [4:0]       exp_x;
   logic             is_nl;
   logic             is_end;
   logic             fempty;
   logic             gap_mid;
   logic             gap_row;
   logic             ovf;
   logic             store;
   logic [CNT_W-1:0] gap_cnt_nx;

   always_comb begin
      cap_eff = (cfg.field_capacity == 5'd0) ? 5'd1 : cfg.field_capacity;
      pos_top = (cap_eff > POS_LIMIT) ? POS_LIMIT : cap_eff;
      pos_x   = 5'(pos_ff);
      col_x   = 5'(col_ff);
      exp_x   = {1'b0, cfg.expected_fields};

      // newline wins when the delimiter is also 10
      is_nl   = (data_byte == NEWLINE_BYTE);
      is_end  = is_nl || (data_byte == cfg.delimiter_char);
      fempty  = (pos_ff == '0);

      gap_mid = gap_ff | (is_end & fempty & (col_x < exp_x));
      // short row: fields never reached count as empty
      gap_row = gap_mid | ((col_x + 5'd1) < exp_x);

      ovf     = !is_end && (pos_x >= pos_top);
      store   = !is_end && !ovf && (col_x < exp_x);

      gap_cnt_nx = gap_cnt_ff;
      if (is_nl && gap_row && (gap_cnt_ff != '1)) begin
         gap_cnt_nx = gap_cnt_ff + 1'b1;
      end

      result.char_out         = data_byte;
      result.store_enable     = store;
      result.column_index     = 4'(col_ff);
      result.char_position    = pos_x;
      result.field_end        = is_end;
      result.field_empty      = is_end & fempty;
      result.field_overflow   = ovf;
      result.row_end          = is_nl;
      result.row_incomplete   = is_nl & gap_row;
      result.row_number       = 16'(row_cnt_ff);
      result.incomplete_total = 16'(gap_cnt_nx);
   end

   always_comb begin
      col_in     = col_ff;
      pos_in     = pos_ff;
      gap_in     = gap_ff;
      row_cnt_in = row_cnt_ff;
      gap_cnt_in = gap_cnt_ff;
      if (step) begin
         if (is_end) begin
            pos_in = '0;
            if (is_nl) begin
               col_in     = '0;
               gap_in     = 1'b0;
               gap_cnt_in = gap_cnt_nx;
               if (row_cnt_ff != '1) begin
                  row_cnt_in = row_cnt_ff + 1'b1;
               end
            end else begin
               gap_in = gap_mid;
               if (col_ff < COL_LIMIT) begin
                  col_in = col_ff + 1'b1;
               end
            end
         end else if (!ovf) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         pos_ff     <= '0;
         gap_ff     <= 1'b0;
         row_cnt_ff <= '0;
         gap_cnt_ff <= '0;
      end else begin
         col_ff     <= col_in;
         pos_ff     <= pos_in;
         gap_ff     <= gap_in;
         row_cnt_ff <= row_cnt_in;
         gap_cnt_ff <= gap_cnt_in;
      end
   end

   a_gap_rows_le_rows: assert property (@(posedge clock) disable iff (reset)
      gap_cnt_ff <= row_cnt_ff)
      else $error("incomplete row count exceeds row count");

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      5'(pos_ff) <= POS_LIMIT)
      else $error("field position beyond limit");

   a_newline_clears: assert property (@(posedge clock) disable iff (reset)
      step && is_nl |=> col_ff == '0 && pos_ff == '0 && !gap_ff)
      else $error("row state not cleared after newline");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(row_cnt_ff) && $stable(col_ff) && $stable(pos_ff))
      else $error("tracking state moved without a transaction");

endmodule

`default_nettype wire
